// ===== sv/cssd_pkg.sv =====
// ----------------------------------------------------------------------------
// cssd_pkg - shared types and functions for the seven-segment clock driver
// Holds the segment bit positions, the digit glyph table and the
// descriptor that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package cssd_pkg;

  // segment bits: bit7 dot, bit6 a down to bit0 g
  localparam logic [7:0] SegA   = 8'h40;
  localparam logic [7:0] SegB   = 8'h20;
  localparam logic [7:0] SegC   = 8'h10;
  localparam logic [7:0] SegD   = 8'h08;
  localparam logic [7:0] SegE   = 8'h04;
  localparam logic [7:0] SegF   = 8'h02;
  localparam logic [7:0] SegG   = 8'h01;
  localparam logic [7:0] SegDot = 8'h80;

  // time limits
  localparam logic [11:0] TimeMax  = 12'd2359;
  localparam logic [11:0] NoonTime = 12'd1200;
  localparam logic [11:0] Pm1Time  = 12'd1300;

  // digit positions
  localparam logic [1:0] PosOnes      = 2'd0;
  localparam logic [1:0] PosTens      = 2'd1;
  localparam logic [1:0] PosHundreds  = 2'd2;
  localparam logic [1:0] PosThousands = 2'd3;

  // register map
  localparam logic [0:0] RegTwelveHour = 1'b0;
  localparam int unsigned QueueDepth = 2;

  // one classified item: four ready patterns, first position to show
  typedef struct packed {
    logic       err;
    logic [1:0] start;
    logic [7:0] pat3;
    logic [7:0] pat2;
    logic [7:0] pat1;
    logic [7:0] pat0;
  } cssd_entry_t;

  // decimal digit to segment pattern
  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = SegA | SegB | SegC | SegD | SegE | SegF;
      4'd1:    p = SegB | SegC;
      4'd2:    p = SegA | SegB | SegG | SegE | SegD;
      4'd3:    p = SegA | SegB | SegC | SegG | SegD;
      4'd4:    p = SegB | SegC | SegF | SegG;
      4'd5:    p = SegA | SegF | SegG | SegC | SegD;
      4'd6:    p = SegA | SegF | SegE | SegG | SegD | SegC;
      4'd7:    p = SegA | SegB | SegC;
      4'd8:    p = SegA | SegB | SegC | SegD | SegE | SegF | SegG;
      4'd9:    p = SegA | SegB | SegC | SegG | SegF;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/cssd_front.sv =====
// ----------------------------------------------------------------------------
// cssd_front - item intake and digit classification
// Splits the time into decimal digits, applies 12-hour folding and the PM
// dot, picks the first unblanked position and builds the glyphs.
// ----------------------------------------------------------------------------
module cssd_front import cssd_pkg::*; (
  input  logic [11:0] time_value,
  input  logic [5:0]  seconds,
  input  logic        twelve_hour_mode,
  output cssd_entry_t entry
);

  logic        pm_dot;
  logic [11:0] shown;
  logic [1:0]  d3;
  logic [11:0] r1;
  logic [3:0]  d2;
  logic [6:0]  r2;
  logic [3:0]  d1;
  logic [3:0]  d0;
  logic [11:0] h_sub;
  logic [6:0]  t_sub;

  // 12-hour folding: from 1300 upward a single subtract of 1200, so 12xx stays
  always_comb begin
    pm_dot = twelve_hour_mode && (time_value >= NoonTime);
    shown  = (twelve_hour_mode && (time_value >= Pm1Time)) ? time_value - NoonTime
                                                           : time_value;
  end

  // thousands digit and remainder
  always_comb begin
    if (shown >= 12'd2000) begin
      d3 = 2'd2;
      r1 = shown - 12'd2000;
    end else if (shown >= 12'd1000) begin
      d3 = 2'd1;
      r1 = shown - 12'd1000;
    end else begin
      d3 = 2'd0;
      r1 = shown;
    end
  end

  // hundreds digit by parallel compares
  always_comb begin
    d2    = 4'd0;
    h_sub = 12'd0;
    for (int k = 1; k <= 9; k++) begin
      if (r1 >= 12'(k * 100)) begin
        d2    = 4'(k);
        h_sub = 12'(k * 100);
      end
    end
    r2 = 7'(r1 - h_sub);
  end

  // tens and ones digits
  always_comb begin
    d1    = 4'd0;
    t_sub = 7'd0;
    for (int k = 1; k <= 9; k++) begin
      if (r2 >= 7'(k * 10)) begin
        d1    = 4'(k);
        t_sub = 7'(k * 10);
      end
    end
    d0 = 4'(r2 - t_sub);
  end

  // descriptor for the back end
  always_comb begin
    entry.err  = time_value > TimeMax;
    entry.pat3 = glyph({2'b00, d3});
    entry.pat2 = glyph(d2) | (pm_dot ? SegDot : 8'h00);
    entry.pat1 = glyph(d1);
    entry.pat0 = glyph(d0) | (seconds[0] ? SegDot : 8'h00);
    if (entry.err)          entry.start = PosOnes;
    else if (d3 != 2'd0)    entry.start = PosThousands;
    else if (d2 != 4'd0)    entry.start = PosHundreds;
    else if (d1 != 4'd0)    entry.start = PosTens;
    else                    entry.start = PosOnes;
  end

endmodule

// ===== sv/cssd_queue.sv =====
// ----------------------------------------------------------------------------
// cssd_queue - two-entry queue between front and back
// Lets the front take items while the back is still emitting digits.
// ----------------------------------------------------------------------------
module cssd_queue import cssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cssd_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output logic        not_empty,
  output cssd_entry_t head
);

  cssd_entry_t mem [QueueDepth];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = count == 2'(QueueDepth);
  assign not_empty = count != 2'd0;
  assign head      = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !not_empty |-> !pop) else $error("pop from empty queue");

endmodule

// ===== sv/cssd_back.sv =====
// ----------------------------------------------------------------------------
// cssd_back - digit sequencer and output register
// Walks the queue head from its first shown position down to the ones
// digit, one result item per cycle while out_ready allows, into a registered output.
// ----------------------------------------------------------------------------
module cssd_back import cssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cssd_entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  digit_select,
  output logic [7:0]  segment_pattern,
  output logic        range_error,
  output logic        last_digit
);

  logic       started;
  logic [1:0] pos;
  logic [1:0] cur;
  logic       load;
  logic       is_last;
  logic [7:0] pat;

  // current position and pattern
  always_comb begin
    cur     = started ? pos : head.start;
    is_last = head.err || (cur == PosOnes);
    load    = q_valid && (!out_valid || out_ready);
    pop     = load && is_last;
    case (cur)
      PosThousands: pat = head.pat3;
      PosHundreds:  pat = head.pat2;
      PosTens:      pat = head.pat1;
      PosOnes:      pat = head.pat0;
      default:      pat = 8'h00;
    endcase
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      pos       <= PosOnes;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        started   <= !is_last;
        pos       <= cur - 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      digit_select    <= head.err ? PosOnes : cur;
      segment_pattern <= head.err ? 8'h00 : pat;
      range_error     <= head.err;
      last_digit      <= is_last;
    end
  end

  // checks
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last_digit && segment_pattern == 8'h00 &&
    digit_select == PosOnes) else $error("error item not a single blank result");
  a_last_is_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_digit |-> digit_select != PosOnes)
    else $error("ones digit not marked last");
  a_step_down: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_digit |=>
    out_valid && digit_select == $past(digit_select) - 2'd1)
    else $error("digit sequence broken");

endmodule

// ===== sv/clock_seven_segment_digit_driver.sv =====
// ----------------------------------------------------------------------------
// clock_seven_segment_digit_driver - top level of the clock digit driver
// Takes HHMM times and seconds, gives one segment item per shown digit.
// ----------------------------------------------------------------------------
// Each accepted time gives one to four result items, highest shown position
// first, ending with the ones digit (last_digit high); a time above 2359
// gives a single blank item with range_error high. The back end sends one
// result item per cycle while out_ready allows, one per shown digit; a
// two-entry queue behind the front end lets new items in while the back end
// is still working, so with an always-ready sink the throughput is set by
// the back end's one-digit-per-cycle output register.
// An input time passes the queue storage and then the output register.
module clock_seven_segment_digit_driver import cssd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] time_value,
  input  logic [5:0]  seconds,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  digit_select,
  output logic [7:0]  segment_pattern,
  output logic        range_error,
  output logic        last_digit
);

  logic        twelve_hour_mode;
  cssd_entry_t entry;
  cssd_entry_t head;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  logic        push;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      twelve_hour_mode <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == RegTwelveHour) begin
      twelve_hour_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == RegTwelveHour) prdata[0] = twelve_hour_mode;
  end

  // intake
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  cssd_front u_front (
    .time_value       (time_value),
    .seconds          (seconds),
    .twelve_hour_mode (twelve_hour_mode),
    .entry            (entry)
  );

  cssd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head)
  );

  cssd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .head            (head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .digit_select    (digit_select),
    .segment_pattern (segment_pattern),
    .range_error     (range_error),
    .last_digit      (last_digit)
  );

endmodule
